// ===== sv/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define WFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wfs assertion failed");

// Check the consequent in the cycle after the antecedent.
`define WFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wfs assertion failed");

`endif

// ===== sv/wfs_pkg.sv =====
`default_nettype none

package wfs_pkg;

  // Width of every configuration register and of the random word
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumCfg = 6;
  // Timer and pending delays hold base plus scaled share
  localparam int unsigned TimerW = 17;
  localparam int unsigned LevelW = 8;
  localparam int unsigned PhaseW = 3;

  // Command codes of an input item
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_ON     = 3'd1,
    CMD_OFF    = 3'd2,
    CMD_APPEND = 3'd3,
    CMD_WRITE  = 3'd4
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_BASE   = 3'd0,
    CFG_START_SPREAD = 3'd1,
    CFG_END_BASE     = 3'd2,
    CFG_END_SPREAD   = 3'd3,
    CFG_PAUSE_BASE   = 3'd4,
    CFG_PAUSE_SPREAD = 3'd5
  } cfg_idx_e;

  // Phase codes as shown on the result
  localparam logic [PhaseW-1:0] PHC_OFF   = 3'd0;
  localparam logic [PhaseW-1:0] PHC_START = 3'd1;
  localparam logic [PhaseW-1:0] PHC_EVEN  = 3'd2;
  localparam logic [PhaseW-1:0] PHC_ODD   = 3'd3;
  localparam logic [PhaseW-1:0] PHC_PAUSE = 3'd4;
  localparam logic [PhaseW-1:0] PHC_END   = 3'd5;

  // Sequencer phase, one-hot
  typedef enum logic [5:0] {
    PH_OFF   = 6'b000001,
    PH_START = 6'b000010,
    PH_EVEN  = 6'b000100,
    PH_ODD   = 6'b001000,
    PH_PAUSE = 6'b010000,
    PH_END   = 6'b100000
  } phase_e;

  // Map the one-hot phase onto its result code
  function automatic logic [PhaseW-1:0] phase_code(input phase_e ph);
    logic [PhaseW-1:0] code;
    case (ph)
      PH_START: code = PHC_START;
      PH_EVEN:  code = PHC_EVEN;
      PH_ODD:   code = PHC_ODD;
      PH_PAUSE: code = PHC_PAUSE;
      PH_END:   code = PHC_END;
      default:  code = PHC_OFF;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== sv/wfs_level_store.sv =====
`default_nettype none

// Pattern level memory: one write and one registered read a cycle.
// A write to the address being read this cycle is forwarded, so the
// read data always shows the latest value.
module wfs_level_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_en_i,
  input  wire logic [AddrW-1:0]             wr_addr_i,
  input  wire logic [wfs_pkg::LevelW-1:0]   wr_data_i,
  input  wire logic [AddrW-1:0]             rd_addr_i,
  output logic      [wfs_pkg::LevelW-1:0]   rd_data_o
);

  logic [wfs_pkg::LevelW-1:0] mem_q [Depth];
  logic [wfs_pkg::LevelW-1:0] rd_q;
  logic [wfs_pkg::LevelW-1:0] byp_data_q;
  logic                       byp_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[rd_addr_i == wr_addr_i ? wr_addr_i : wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rd_q       <= mem_q[rd_addr_i];
    byp_data_q <= wr_data_i;
  end

  // Note a same-address write for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire

// ===== sv/weld_flicker_sequencer_core.sv =====
`default_nettype none

// Welding-flicker sequencer for an LED drive.
// Input channel (in_valid_i / in_stall_o) carries one command item: tick, turn
// on, turn off, append a pattern descriptor or write a pattern level byte.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// item: drive level, PWM flag, a flag telling whether the item wrote the drive,
// and the phase after the item.
// Configuration registers are written through cfg_we_i / cfg_index_i /
// cfg_data_i; the user must write them only while no item is in flight, as
// the block itself does not enforce it. An accepted item sits in the input
// register and is then worked into the result register, where its result is
// shown until taken. Throughput: one item per cycle while the receiver does
// not stall; the whole step is one pass of next-state logic with a single
// 16x16 multiplier for the random scaling, and the level memory is read ahead
// from the next state so its registered port adds no wait.
// Reset clears the phase, timers, pattern count, drive level and registers;
// pattern descriptors and level bytes are undefined until written.
// While the receiver stalls the result holds, one more item waits in the input
// register, and in_stall_o rises only once both registers are full.
module weld_flicker_sequencer_core #(
  parameter int unsigned MAX_PATTERNS = 4,
  parameter int unsigned MAX_STEPS    = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [2:0]                    command_i,
  input  wire logic [15:0]                   random_word_i,
  input  wire logic [1:0]                    slot_select_i,
  input  wire logic [7:0]                    byte_position_i,
  input  wire logic [7:0]                    byte_level_i,
  input  wire logic [8:0]                    step_count_i,
  input  wire logic [15:0]                   step_ticks_i,
  input  wire logic                          pwm_select_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         drive_level_o,
  output logic                               drive_pwm_o,
  output logic                               drive_written_o,
  output logic [2:0]                         phase_o,
  // Configuration port
  input  wire logic                          cfg_we_i,
  input  wire logic [wfs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [wfs_pkg::CfgW-1:0]      cfg_data_i
);

  localparam int unsigned SlotW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned NumW  = $clog2(MAX_PATTERNS + 1);
  localparam int unsigned PosW  = $clog2(MAX_STEPS + 1);
  localparam int unsigned Depth = MAX_PATTERNS * MAX_STEPS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned TW    = wfs_pkg::TimerW;
  localparam int unsigned CW    = wfs_pkg::CfgW;

  // Input register
  logic                       in_valid_q;
  wfs_pkg::cmd_e              cmd_q;
  logic [15:0]                rnd_q;
  logic [1:0]                 slot_q;
  logic [7:0]                 bpos_q;
  logic [7:0]                 blvl_q;
  logic [8:0]                 scnt_q;
  logic [15:0]                sticks_q;
  logic                       spwm_q;

  // Configuration
  logic [CW-1:0]              cfg_q [wfs_pkg::NumCfg];

  // Sequencer state
  wfs_pkg::phase_e            now_q, now_d;
  wfs_pkg::phase_e            want_q, want_d;
  logic [TW-1:0]              cd_q, cd_d;
  logic [TW-1:0]              pstart_q, pstart_d;
  logic [TW-1:0]              pend_q, pend_d;
  logic [NumW-1:0]            num_q, num_d;
  logic [SlotW-1:0]           act_q, act_d;
  logic [PosW-1:0]            pos_q, pos_d;
  logic [wfs_pkg::LevelW-1:0] lvl_q, lvl_d;
  logic                       pwm_q, pwm_d;
  logic                       wr_q, wr_d;
  logic                       out_valid_q;

  // Descriptor tables
  logic [PosW-1:0]            len_q [MAX_PATTERNS];
  logic [15:0]                per_q [MAX_PATTERNS];
  logic                       spm_q [MAX_PATTERNS];

  // Handshake control
  logic                       advance;
  logic                       proc;
  logic                       in_load;

  // Datapath
  logic [CW-1:0]              bound;
  logic [31:0]                prod;
  logic [CW-1:0]              scaled;
  logic [wfs_pkg::LevelW-1:0] mem_rd;
  logic                       mem_we;
  logic [AddrW-1:0]           mem_waddr;
  logic [AddrW-1:0]           mem_raddr;
  logic [TW-1:0]              cd_dec;
  logic [PosW-1:0]            pos_inc;
  logic [PosW-1:0]            len_sat;
  logic                       app_ok;
  logic [31:0]                pos_idx;

  // Move items when the result register is free or being emptied
  assign advance    = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  // Capture the item payload
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      cmd_q    <= wfs_pkg::cmd_e'(command_i);
      rnd_q    <= random_word_i;
      slot_q   <= slot_select_i;
      bpos_q   <= byte_position_i;
      blvl_q   <= byte_level_i;
      scnt_q   <= step_count_i;
      sticks_q <= step_ticks_i;
      spwm_q   <= pwm_select_i;
    end
  end

  // Configuration writes; indexes beyond the list drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wfs_pkg::NumCfg; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (wfs_pkg::cfg_idx_e'(cfg_index_i))
        wfs_pkg::CFG_START_BASE:   cfg_q[0] <= cfg_data_i;
        wfs_pkg::CFG_START_SPREAD: cfg_q[1] <= cfg_data_i;
        wfs_pkg::CFG_END_BASE:     cfg_q[2] <= cfg_data_i;
        wfs_pkg::CFG_END_SPREAD:   cfg_q[3] <= cfg_data_i;
        wfs_pkg::CFG_PAUSE_BASE:   cfg_q[4] <= cfg_data_i;
        wfs_pkg::CFG_PAUSE_SPREAD: cfg_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pick the bound for the one random scaling this item needs
  always_comb begin
    case (cmd_q)
      wfs_pkg::CMD_ON:  bound = cfg_q[1];
      wfs_pkg::CMD_OFF: bound = cfg_q[3];
      default: begin
        if (want_q != now_q) begin
          bound = cfg_q[5];
        end else begin
          bound = CW'(num_q);
        end
      end
    endcase
  end

  assign prod   = 32'(rnd_q) * 32'(bound);
  assign scaled = prod[31:16];

  // Descriptor append and byte write qualifiers
  assign app_ok  = (32'(num_q) < MAX_PATTERNS);
  assign len_sat = (32'(scnt_q) > MAX_STEPS) ? PosW'(MAX_STEPS) : PosW'(scnt_q);
  assign mem_we  = proc && (cmd_q == wfs_pkg::CMD_WRITE) &&
                   (32'(slot_q) < MAX_PATTERNS) && (32'(bpos_q) < MAX_STEPS);
  assign mem_waddr = AddrW'(32'(slot_q) * MAX_STEPS + 32'(bpos_q));

  assign cd_dec  = (cd_q != '0) ? cd_q - TW'(1) : cd_q;
  assign pos_inc = pos_q + PosW'(1);

  // Next-state logic for one item
  always_comb begin
    now_d    = now_q;
    want_d   = want_q;
    cd_d     = cd_q;
    pstart_d = pstart_q;
    pend_d   = pend_q;
    num_d    = num_q;
    act_d    = act_q;
    pos_d    = pos_q;
    lvl_d    = lvl_q;
    pwm_d    = pwm_q;
    wr_d     = 1'b0;
    if (proc) begin
      case (cmd_q)
        wfs_pkg::CMD_ON: begin
          want_d   = wfs_pkg::PH_START;
          pstart_d = TW'(cfg_q[0]) + TW'(scaled);
        end
        wfs_pkg::CMD_OFF: begin
          want_d = wfs_pkg::PH_END;
          pend_d = TW'(cfg_q[2]) + TW'(scaled);
        end
        wfs_pkg::CMD_APPEND: begin
          if (app_ok) begin
            num_d = num_q + NumW'(1);
          end
        end
        wfs_pkg::CMD_TICK: begin
          if (want_q != now_q) begin
            // Enter the wanted phase
            now_d = want_q;
            case (want_q)
              wfs_pkg::PH_OFF: begin
                lvl_d = '0;
                pwm_d = 1'b0;
                wr_d  = 1'b1;
              end
              wfs_pkg::PH_PAUSE: begin
                lvl_d = '0;
                pwm_d = 1'b0;
                wr_d  = 1'b1;
                cd_d  = TW'(cfg_q[4]) + TW'(scaled);
              end
              wfs_pkg::PH_EVEN, wfs_pkg::PH_ODD: begin
                lvl_d = mem_rd;
                pwm_d = spm_q[act_q];
                wr_d  = 1'b1;
                cd_d  = TW'(per_q[act_q]);
              end
              wfs_pkg::PH_START: cd_d = pstart_q;
              default:           cd_d = pend_q;
            endcase
          end else begin
            // Count down and act on expiry
            cd_d = cd_dec;
            if (cd_dec == '0) begin
              case (now_q)
                wfs_pkg::PH_START, wfs_pkg::PH_PAUSE: begin
                  if (num_q != '0) begin
                    act_d  = SlotW'(scaled);
                    pos_d  = '0;
                    want_d = wfs_pkg::PH_EVEN;
                  end
                end
                wfs_pkg::PH_END: want_d = wfs_pkg::PH_OFF;
                wfs_pkg::PH_EVEN, wfs_pkg::PH_ODD: begin
                  pos_d = pos_inc;
                  if (pos_inc >= len_q[act_q]) begin
                    want_d = wfs_pkg::PH_PAUSE;
                  end else if (now_q == wfs_pkg::PH_EVEN) begin
                    want_d = wfs_pkg::PH_ODD;
                  end else begin
                    want_d = wfs_pkg::PH_EVEN;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= wfs_pkg::PH_OFF;
      want_q      <= wfs_pkg::PH_OFF;
      cd_q        <= '0;
      pstart_q    <= '0;
      pend_q      <= '0;
      num_q       <= '0;
      act_q       <= '0;
      pos_q       <= '0;
      lvl_q       <= '0;
      pwm_q       <= 1'b0;
      wr_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      now_q    <= now_d;
      want_q   <= want_d;
      cd_q     <= cd_d;
      pstart_q <= pstart_d;
      pend_q   <= pend_d;
      num_q    <= num_d;
      act_q    <= act_d;
      pos_q    <= pos_d;
      lvl_q    <= lvl_d;
      pwm_q    <= pwm_d;
      if (advance) begin
        wr_q        <= wr_d;
        out_valid_q <= proc;
      end
    end
  end

  // Store appended descriptors
  always_ff @(posedge clk_i) begin
    if (proc && (cmd_q == wfs_pkg::CMD_APPEND) && app_ok) begin
      len_q[SlotW'(num_q)] <= len_sat;
      per_q[SlotW'(num_q)] <= sticks_q;
      spm_q[SlotW'(num_q)] <= spwm_q;
    end
  end

  // Read the level memory ahead at the next slot and position
  assign pos_idx   = (32'(pos_d) >= MAX_STEPS) ? 32'd0 : 32'(pos_d);
  assign mem_raddr = AddrW'(32'(act_d) * MAX_STEPS + pos_idx);

  wfs_level_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_level_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (blvl_q),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rd)
  );

  assign out_valid_o     = out_valid_q;
  assign drive_level_o   = lvl_q;
  assign drive_pwm_o     = pwm_q;
  assign drive_written_o = wr_q;
  assign phase_o         = wfs_pkg::phase_code(now_q);

endmodule

`default_nettype wire

// ===== sv/wfs_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the sequencer.
module wfs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_i,
  input wire logic       out_valid_i,
  input wire logic       out_stall_i,
  input wire logic [7:0] drive_level_i,
  input wire logic       drive_pwm_i,
  input wire logic       drive_written_i,
  input wire logic [2:0] phase_i
);

  // Stall the input only while a valid result is held by the receiver
  `WFS_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_i, in_valid_i || (out_valid_i && out_stall_i))
  `WFS_ASSERT_NOW(a_stall_full, clk_i, rst_ni, in_stall_i, out_valid_i && out_stall_i)

  // Hold the result while the receiver stalls
  `WFS_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(drive_level_i) && $stable(drive_pwm_i) && $stable(drive_written_i) && $stable(phase_i))

  // Drop the drive in off and pause
  `WFS_ASSERT_NOW(a_dark, clk_i, rst_ni, out_valid_i && (phase_i == wfs_pkg::PHC_OFF || phase_i == wfs_pkg::PHC_PAUSE), drive_level_i == 8'd0 && !drive_pwm_i)

  // Never write the drive on entering start or end
  `WFS_ASSERT_NOW(a_no_write, clk_i, rst_ni, out_valid_i && drive_written_i, phase_i != wfs_pkg::PHC_START && phase_i != wfs_pkg::PHC_END)

endmodule

bind weld_flicker_sequencer_core wfs_checker u_wfs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_i      (in_stall_o),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .drive_level_i   (drive_level_o),
  .drive_pwm_i     (drive_pwm_o),
  .drive_written_i (drive_written_o),
  .phase_i         (phase_o)
);

`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top;

  localparam int unsigned SLOTS       = 4;
  localparam int unsigned STEPS       = 256;
  localparam int unsigned WATCH_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 24;
  localparam int unsigned SWEEP_TICKS = 520;
  localparam int unsigned TW          = wfs_pkg::TimerW;
  localparam int unsigned IW          = wfs_pkg::CfgIdxW;

  // Command codes the block leaves unused
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] rnd;
    logic [1:0]  slot;
    logic [7:0]  pos;
    logic [7:0]  lvl;
    logic [8:0]  cnt;
    logic [15:0] per;
    logic        pwm;
  } item_t;

  typedef struct packed {
    logic [wfs_pkg::LevelW-1:0] level;
    logic                       pwm;
    logic                       written;
    logic [wfs_pkg::PhaseW-1:0] phase;
  } drive_t;

  typedef struct packed {
    item_t  it;
    logic   typed;
    drive_t res;
  } row_t;

  // Block ports
  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [2:0]                 command;
  logic [15:0]                random_word;
  logic [1:0]                 slot_select;
  logic [7:0]                 byte_position;
  logic [7:0]                 byte_level;
  logic [8:0]                 step_count;
  logic [15:0]                step_ticks;
  logic                       pwm_select;
  logic                       out_valid;
  logic                       out_stall;
  logic [7:0]                 drive_level;
  logic                       drive_pwm;
  logic                       drive_written;
  logic [2:0]                 phase;
  logic                       cfg_we;
  logic [IW-1:0]              cfg_index;
  logic [wfs_pkg::CfgW-1:0]   cfg_data;

  // Sequencer shadow state
  logic [wfs_pkg::CfgW-1:0]   cfg_q [wfs_pkg::NumCfg];
  logic [wfs_pkg::PhaseW-1:0] ph_now, ph_want;
  logic [TW-1:0]              count_q, pend_start, pend_end;
  int unsigned                n_defined;
  logic [1:0]                 act_slot;
  logic [8:0]                 step_pos;
  logic [8:0]                 len_q [SLOTS];
  logic [15:0]                per_q [SLOTS];
  logic                       pwm_q [SLOTS];
  logic [7:0]                 lvl_mem [SLOTS*STEPS];
  logic [7:0]                 lvl_out;
  logic                       pwm_out;

  drive_t                     drive_results_q [$];
  logic [wfs_pkg::CfgW-1:0]   cfg_plan [wfs_pkg::NumCfg];
  row_t                       dir_tab [20];
  int                         mismatches = 0;
  int                         quiet_cycles = 0;
  int                         tx_idle_pct = 0;
  int                         rx_stall_pct = 0;
  drive_t                     exp_r, got_r;

  weld_flicker_sequencer_core #(
    .MAX_PATTERNS(SLOTS),
    .MAX_STEPS   (STEPS)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .random_word_i  (random_word),
    .slot_select_i  (slot_select),
    .byte_position_i(byte_position),
    .byte_level_i   (byte_level),
    .step_count_i   (step_count),
    .step_ticks_i   (step_ticks),
    .pwm_select_i   (pwm_select),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .drive_level_o  (drive_level),
    .drive_pwm_o    (drive_pwm),
    .drive_written_o(drive_written),
    .phase_o        (phase),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #5 clk = ~clk;

  // Scale a random word into [0, bound) by multiply-high
  function automatic logic [15:0] rand_share(input logic [15:0] word, input logic [15:0] bound);
    logic [31:0] prod;
    prod = {16'd0, word} * {16'd0, bound};
    return prod[31:16];
  endfunction

  function automatic item_t make_item(input logic [2:0] c, input logic [15:0] r,
                                      input logic [1:0] s, input logic [7:0] p,
                                      input logic [7:0] l, input logic [8:0] n,
                                      input logic [15:0] t, input logic w);
    item_t it;
    it.cmd  = c;
    it.rnd  = r;
    it.slot = s;
    it.pos  = p;
    it.lvl  = l;
    it.cnt  = n;
    it.per  = t;
    it.pwm  = w;
    return it;
  endfunction

  // Advance the shadow sequencer by one item and return the drive it shows
  task automatic flicker_predict(input item_t it, output drive_t res);
    logic written;
    written = 1'b0;
    case (it.cmd)
      wfs_pkg::CMD_ON: begin
        ph_want    = wfs_pkg::PHC_START;
        pend_start = TW'(cfg_q[wfs_pkg::CFG_START_BASE])
                   + TW'(rand_share(it.rnd, cfg_q[wfs_pkg::CFG_START_SPREAD]));
      end
      wfs_pkg::CMD_OFF: begin
        ph_want  = wfs_pkg::PHC_END;
        pend_end = TW'(cfg_q[wfs_pkg::CFG_END_BASE])
                 + TW'(rand_share(it.rnd, cfg_q[wfs_pkg::CFG_END_SPREAD]));
      end
      wfs_pkg::CMD_APPEND: begin
        if (n_defined < SLOTS) begin
          len_q[n_defined] = (it.cnt > 9'(STEPS)) ? 9'(STEPS) : it.cnt;
          per_q[n_defined] = it.per;
          pwm_q[n_defined] = it.pwm;
          n_defined++;
        end
      end
      wfs_pkg::CMD_WRITE: lvl_mem[{it.slot, it.pos}] = it.lvl;
      wfs_pkg::CMD_TICK: begin
        if (ph_want != ph_now) begin
          // Apply the pending phase change
          ph_now = ph_want;
          case (ph_now)
            wfs_pkg::PHC_OFF: begin
              lvl_out = '0;
              pwm_out = 1'b0;
              written = 1'b1;
            end
            wfs_pkg::PHC_PAUSE: begin
              lvl_out = '0;
              pwm_out = 1'b0;
              written = 1'b1;
              count_q = TW'(cfg_q[wfs_pkg::CFG_PAUSE_BASE])
                      + TW'(rand_share(it.rnd, cfg_q[wfs_pkg::CFG_PAUSE_SPREAD]));
            end
            wfs_pkg::PHC_EVEN, wfs_pkg::PHC_ODD: begin
              lvl_out = lvl_mem[{act_slot, step_pos[7:0]}];
              pwm_out = pwm_q[act_slot];
              written = 1'b1;
              count_q = TW'(per_q[act_slot]);
            end
            wfs_pkg::PHC_START: count_q = pend_start;
            default:            count_q = pend_end;
          endcase
        end else begin
          // Count down, then act on expiry
          if (count_q != '0) count_q = count_q - 1'b1;
          if (count_q == '0) begin
            if (ph_now == wfs_pkg::PHC_START || ph_now == wfs_pkg::PHC_PAUSE) begin
              if (n_defined != 0) begin
                act_slot = 2'(rand_share(it.rnd, 16'(n_defined)));
                step_pos = '0;
                ph_want  = wfs_pkg::PHC_EVEN;
              end
            end else if (ph_now == wfs_pkg::PHC_END) begin
              ph_want = wfs_pkg::PHC_OFF;
            end else if (ph_now == wfs_pkg::PHC_EVEN || ph_now == wfs_pkg::PHC_ODD) begin
              step_pos = step_pos + 9'd1;
              if (step_pos >= len_q[act_slot]) ph_want = wfs_pkg::PHC_PAUSE;
              else ph_want = (ph_now == wfs_pkg::PHC_EVEN) ? wfs_pkg::PHC_ODD
                                                           : wfs_pkg::PHC_EVEN;
            end
          end
        end
      end
      default: ;
    endcase
    res = '{lvl_out, pwm_out, written, ph_now};
  endtask

  // Offer one item, hold it until taken, then log its expected drive
  task automatic send_item(input item_t it, input logic typed, input drive_t typed_res);
    drive_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= it.cmd;
    random_word   <= it.rnd;
    slot_select   <= it.slot;
    byte_position <= it.pos;
    byte_level    <= it.lvl;
    step_count    <= it.cnt;
    step_ticks    <= it.per;
    pwm_select    <= it.pwm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    flicker_predict(it, res);
    drive_results_q.push_back(typed ? typed_res : res);
  endtask

  // Drain the block, then write every register from the plan and random data to the indexes past the list
  task automatic load_registers();
    in_valid <= 1'b0;
    while (drive_results_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    for (int i = 0; i < wfs_pkg::NumCfg + 2; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= IW'(i);
      cfg_data  <= (i < wfs_pkg::NumCfg) ? cfg_plan[i] : 16'($urandom);
      if (i < wfs_pkg::NumCfg) cfg_q[i] = cfg_plan[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Check each taken result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_r = '{drive_level, drive_pwm, drive_written, phase};
      if (drive_results_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result level %0d pwm %0d written %0d phase %0d",
                 $time, got_r.level, got_r.pwm, got_r.written, got_r.phase);
      end else begin
        exp_r = drive_results_q.pop_front();
        if (got_r !== exp_r) begin
          mismatches++;
          $display({"%0t: expected level %0d pwm %0d written %0d phase %0d, ",
                    "got level %0d pwm %0d written %0d phase %0d"},
                   $time, exp_r.level, exp_r.pwm, exp_r.written, exp_r.phase,
                   got_r.level, got_r.pwm, got_r.written, got_r.phase);
        end
      end
    end
  end

  // Count cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCH_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    item_t it;
    drive_t none;
    int r;
    int len2, len3;

    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    command = '0;
    random_word = '0;
    slot_select = '0;
    byte_position = '0;
    byte_level = '0;
    step_count = '0;
    step_ticks = '0;
    pwm_select = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    // Shadow state after reset
    foreach (cfg_q[i]) cfg_q[i] = '0;
    ph_now = wfs_pkg::PHC_OFF;
    ph_want = wfs_pkg::PHC_OFF;
    count_q = '0;
    pend_start = '0;
    pend_end = '0;
    n_defined = 0;
    act_slot = '0;
    step_pos = '0;
    foreach (len_q[i]) begin
      len_q[i] = '0;
      per_q[i] = '0;
      pwm_q[i] = 1'b0;
    end
    foreach (lvl_mem[i]) lvl_mem[i] = '0;
    lvl_out = '0;
    pwm_out = 1'b0;

    // Walk one zero-length pattern through start, step, pause, end and off
    dir_tab = '{
      '{make_item(wfs_pkg::CMD_TICK, 16'h0000, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'h00, 1'b0, 1'b0, wfs_pkg::PHC_OFF}},
      '{make_item(CMD_UNUSED_LO, 16'h0000, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'h00, 1'b0, 1'b0, wfs_pkg::PHC_OFF}},
      '{make_item(CMD_UNUSED_HI, 16'hFFFF, 2'd3, 8'hFF, 8'hFF, 9'h1FF, 16'hFFFF, 1'b1),
        1'b1, '{8'h00, 1'b0, 1'b0, wfs_pkg::PHC_OFF}},
      '{make_item(wfs_pkg::CMD_ON, 16'hFFFF, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'h00, 1'b0, 1'b0, wfs_pkg::PHC_OFF}},
      '{make_item(wfs_pkg::CMD_TICK, 16'hFFFF, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'h00, 1'b0, 1'b0, wfs_pkg::PHC_START}},
      '{make_item(wfs_pkg::CMD_TICK, 16'h0000, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'h00, 1'b0, 1'b0, wfs_pkg::PHC_START}},
      '{make_item(wfs_pkg::CMD_WRITE, 16'h0000, 2'd0, 8'h00, 8'hFF, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'h00, 1'b0, 1'b0, wfs_pkg::PHC_START}},
      '{make_item(wfs_pkg::CMD_APPEND, 16'h0000, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b1),
        1'b1, '{8'h00, 1'b0, 1'b0, wfs_pkg::PHC_START}},
      '{make_item(wfs_pkg::CMD_TICK, 16'h0000, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'h00, 1'b0, 1'b0, wfs_pkg::PHC_START}},
      '{make_item(wfs_pkg::CMD_TICK, 16'h0000, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'hFF, 1'b1, 1'b1, wfs_pkg::PHC_EVEN}},
      '{make_item(wfs_pkg::CMD_TICK, 16'h0000, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'hFF, 1'b1, 1'b0, wfs_pkg::PHC_EVEN}},
      '{make_item(wfs_pkg::CMD_TICK, 16'hFFFF, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'h00, 1'b0, 1'b1, wfs_pkg::PHC_PAUSE}},
      '{make_item(wfs_pkg::CMD_TICK, 16'hFFFF, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'h00, 1'b0, 1'b0, wfs_pkg::PHC_PAUSE}},
      '{make_item(wfs_pkg::CMD_OFF, 16'hFFFF, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'h00, 1'b0, 1'b0, wfs_pkg::PHC_PAUSE}},
      '{make_item(wfs_pkg::CMD_TICK, 16'h0000, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'h00, 1'b0, 1'b0, wfs_pkg::PHC_END}},
      '{make_item(wfs_pkg::CMD_TICK, 16'h0000, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'h00, 1'b0, 1'b0, wfs_pkg::PHC_END}},
      '{make_item(wfs_pkg::CMD_TICK, 16'h0000, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b1, '{8'h00, 1'b0, 1'b1, wfs_pkg::PHC_OFF}},
      '{make_item(wfs_pkg::CMD_WRITE, 16'hFFFF, 2'd3, 8'hFF, 8'h55, 9'h1FF, 16'hFFFF, 1'b1),
        1'b0, '0},
      '{make_item(wfs_pkg::CMD_WRITE, 16'h0000, 2'd2, 8'h80, 8'hAA, 9'h000, 16'h0000, 1'b0),
        1'b0, '0},
      '{make_item(wfs_pkg::CMD_TICK, 16'h0000, 2'd0, 8'h00, 8'h00, 9'h000, 16'h0000, 1'b0),
        1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

    // Fill slot 1 completely; its step count saturates to the full length
    for (int p = 0; p < STEPS; p++)
      send_item(make_item(wfs_pkg::CMD_WRITE, 16'($urandom), 2'd1, 8'(p), 8'($urandom),
                          9'($urandom), 16'($urandom), 1'($urandom)), 1'b0, none);
    send_item(make_item(wfs_pkg::CMD_APPEND, 16'($urandom), 2'($urandom), 8'($urandom),
                        8'($urandom), 9'($urandom_range(STEPS + 1, 511)),
                        16'($urandom_range(0, 1)), 1'b0),
              1'b0, none);

    // Short patterns in slots 2 and 3, levels written before the descriptor
    len2 = $urandom_range(1, 8);
    len3 = $urandom_range(1, 12);
    for (int p = 0; p < len2; p++)
      send_item(make_item(wfs_pkg::CMD_WRITE, 16'($urandom), 2'd2, 8'(p), 8'($urandom),
                          9'($urandom), 16'($urandom), 1'($urandom)), 1'b0, none);
    send_item(make_item(wfs_pkg::CMD_APPEND, 16'($urandom), 2'($urandom), 8'($urandom),
                        8'($urandom), 9'(len2), 16'($urandom_range(1, 4)), 1'b1),
              1'b0, none);
    for (int p = 0; p < len3; p++)
      send_item(make_item(wfs_pkg::CMD_WRITE, 16'($urandom), 2'd3, 8'(p), 8'($urandom),
                          9'($urandom), 16'($urandom), 1'($urandom)), 1'b0, none);
    send_item(make_item(wfs_pkg::CMD_APPEND, 16'($urandom), 2'($urandom), 8'($urandom),
                        8'($urandom), 9'(len3), 16'($urandom_range(0, 3)), 1'($urandom)),
              1'b0, none);

    // Descriptor store is full now: these appends must be dropped
    send_item(make_item(wfs_pkg::CMD_APPEND, 16'hFFFF, 2'd3, 8'hFF, 8'hFF, 9'h100, 16'hFFFF,
                        1'b1), 1'b0, none);
    send_item(make_item(wfs_pkg::CMD_APPEND, 16'h0000, 2'd0, 8'h00, 8'h00, 9'h1FF, 16'h0000,
                        1'b0), 1'b0, none);

    // Run slot 1 end to end: every pick lands on it
    send_item(make_item(wfs_pkg::CMD_ON, 16'($urandom), 2'($urandom), 8'($urandom),
                        8'($urandom), 9'($urandom), 16'($urandom), 1'($urandom)),
              1'b0, none);
    for (int n = 0; n < SWEEP_TICKS; n++)
      send_item(make_item(wfs_pkg::CMD_TICK, {2'b01, 14'($urandom)}, 2'($urandom),
                          8'($urandom), 8'($urandom), 9'($urandom), 16'($urandom),
                          1'($urandom)),
                1'b0, none);

    // Random phases, each with a register set and one of four idling modes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: foreach (cfg_plan[i]) cfg_plan[i] = 16'hFFFF;
        2: begin
          cfg_plan[wfs_pkg::CFG_START_BASE]   = '0;
          cfg_plan[wfs_pkg::CFG_START_SPREAD] = 16'd1;
          cfg_plan[wfs_pkg::CFG_END_BASE]     = '0;
          cfg_plan[wfs_pkg::CFG_END_SPREAD]   = 16'd1;
          cfg_plan[wfs_pkg::CFG_PAUSE_BASE]   = '0;
          cfg_plan[wfs_pkg::CFG_PAUSE_SPREAD] = 16'd1;
        end
        5: foreach (cfg_plan[i]) cfg_plan[i] = 16'($urandom);
        default: begin
          cfg_plan[wfs_pkg::CFG_START_BASE]   = 16'($urandom_range(0, 12));
          cfg_plan[wfs_pkg::CFG_START_SPREAD] = 16'($urandom_range(0, 40));
          cfg_plan[wfs_pkg::CFG_END_BASE]     = 16'($urandom_range(0, 12));
          cfg_plan[wfs_pkg::CFG_END_SPREAD]   = 16'($urandom_range(0, 40));
          cfg_plan[wfs_pkg::CFG_PAUSE_BASE]   = 16'($urandom_range(0, 12));
          cfg_plan[wfs_pkg::CFG_PAUSE_SPREAD] = 16'($urandom_range(0, 40));
        end
      endcase
      load_registers();
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = make_item(wfs_pkg::CMD_TICK, 16'($urandom), 2'($urandom), 8'($urandom),
                       8'($urandom), 9'($urandom), 16'($urandom), 1'($urandom));
        r = $urandom_range(99);
        if (r < 70) it.cmd = wfs_pkg::CMD_TICK;
        else if (r < 75) it.cmd = wfs_pkg::CMD_ON;
        else if (r < 80) it.cmd = wfs_pkg::CMD_OFF;
        else if (r < 92) it.cmd = wfs_pkg::CMD_WRITE;
        else if (r < 95) it.cmd = wfs_pkg::CMD_APPEND;
        else it.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        send_item(it, 1'b0, none);
      end
    end

    // Drain and let the output settle
    in_valid <= 1'b0;
    while (drive_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
